[hdl/febt_pkg.sv]
// febt_pkg: shared sizes, codes, structs and helpers of the epoch barrier tracker
// no dependencies; compiled before every other file of the block

package febt_pkg;

   // table geometry
   localparam int MAX_PROCS = 64;
   localparam int IDX_W     = $clog2(MAX_PROCS);
   localparam int NACT_W    = $clog2(MAX_PROCS + 1);

   // field widths
   localparam int CONN_W   = 16;
   localparam int PROC_W   = 22;
   localparam int EPOCH_W  = 32;
   localparam int CNT_W    = 7;
   localparam int STATUS_W = 2;

   localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;
   localparam logic [CNT_W-1:0]   CNT_MAX   = '1;

   // request commands
   typedef enum logic {
      CMD_FENCE = 1'b0,
      CMD_QUERY = 1'b1
   } cmd_type;

   // response status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_UNKNOWN = 2'd2
   } status_type;

   // what a probe does while it walks the chain
   typedef enum logic [1:0] {
      PM_FIND,
      PM_COUNT,
      PM_CHECK
   } probe_mode_type;

   // controller states
   typedef enum logic [1:0] {
      S_IDLE,
      S_FIND,
      S_SCAN2,
      S_DONE
   } state_type;

   // probe handed from cell to cell
   typedef struct packed {
      logic                 valid;
      probe_mode_type       mode;
      logic [CONN_W-1:0]    conn;
      logic [PROC_W-1:0]    proc;
      logic [EPOCH_W-1:0]   operand;
      logic                 found;
      logic [IDX_W-1:0]     found_idx;
      logic [EPOCH_W-1:0]   found_epoch;
      logic                 free_found;
      logic [IDX_W-1:0]     free_idx;
      logic [CNT_W-1:0]     count;
      logic                 all_ok;
   } probe_type;

   // slot write broadcast to the cells
   typedef struct packed {
      logic                 en;
      logic [IDX_W-1:0]     idx;
      logic [CONN_W-1:0]    conn;
      logic [PROC_W-1:0]    proc;
      logic [EPOCH_W-1:0]   epoch;
   } slot_wr_type;

   // saturating epoch increment
   function automatic logic [EPOCH_W-1:0] epoch_sat_inc(input logic [EPOCH_W-1:0] e);
      return (e == EPOCH_MAX) ? e : e + 1'b1;
   endfunction

endpackage

[hdl/febt_if.sv]
// febt_req_if and febt_rsp_if: valid/ready channels of the epoch barrier tracker
// depends on febt_pkg for field widths

interface febt_req_if import febt_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              cmd;
   logic [CONN_W-1:0] conn_id;
   logic [PROC_W-1:0] proc_id;

   modport source (output valid, cmd, conn_id, proc_id, input ready);
   modport sink   (input valid, cmd, conn_id, proc_id, output ready);
endinterface

interface febt_rsp_if import febt_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [EPOCH_W-1:0]  own_epoch;
   logic                reached;
   logic                release_res;
   logic [EPOCH_W-1:0]  group_epoch;

   modport source (output valid, status, own_epoch, reached, release_res, group_epoch,
                   input ready);
   modport sink   (input valid, status, own_epoch, reached, release_res, group_epoch,
                   output ready);
endinterface

[hdl/febt_cell.sv]
// febt_cell: one table slot plus one stage of the probe chain
// depends on febt_pkg for the probe and slot write structs

module febt_cell import febt_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [IDX_W-1:0]  cell_idx,
   input  logic [NACT_W-1:0] n_act,
   input  slot_wr_type       slot_wr,
   input  probe_type         up_probe,
   output probe_type         dn_probe
);

   logic               valid_ff;
   logic [CONN_W-1:0]  conn_ff;
   logic [PROC_W-1:0]  proc_ff;
   logic [EPOCH_W-1:0] epoch_ff;
   probe_type          probe_ff;
   probe_type          probe_in;
   logic               active;
   logic               wr_hit;
   logic               key_hit;

   assign active  = NACT_W'(cell_idx) < n_act;
   assign wr_hit  = slot_wr.en && (slot_wr.idx == cell_idx);
   assign key_hit = valid_ff && (conn_ff == up_probe.conn) && (proc_ff == up_probe.proc);

   // slot occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (wr_hit) begin
         valid_ff <= 1'b1;
      end
   end

   // slot contents
   always_ff @(posedge clock) begin
      if (wr_hit) begin
         conn_ff  <= slot_wr.conn;
         proc_ff  <= slot_wr.proc;
         epoch_ff <= slot_wr.epoch;
      end
   end

   // fold this slot into the passing probe
   always_comb begin
      probe_in = up_probe;
      if (up_probe.valid && active) begin
         case (up_probe.mode)
            PM_FIND: begin
               if (!up_probe.found && key_hit) begin
                  probe_in.found       = 1'b1;
                  probe_in.found_idx   = cell_idx;
                  probe_in.found_epoch = epoch_ff;
               end
               if (!up_probe.free_found && !valid_ff) begin
                  probe_in.free_found = 1'b1;
                  probe_in.free_idx   = cell_idx;
               end
            end
            PM_COUNT: begin
               if (valid_ff && (epoch_ff >= up_probe.operand)) begin
                  probe_in.count = up_probe.count + 1'b1;
               end
            end
            PM_CHECK: begin
               if (!valid_ff || (epoch_ff < up_probe.operand)) begin
                  probe_in.all_ok = 1'b0;
               end
            end
            default: begin
               probe_in = up_probe;
            end
         endcase
      end
   end

   // probe stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff.valid <= 1'b0;
      end else begin
         probe_ff <= probe_in;
      end
   end

   assign dn_probe = probe_ff;

endmodule

[hdl/fence_epoch_barrier_tracker.sv]
// fence_epoch_barrier_tracker: top level, request control and the chain of slot cells
// depends on febt_pkg, febt_if (febt_req_if, febt_rsp_if) and febt_cell
//
// Tracks barrier epochs for up to MAX_PROCS processes, one table slot per cell in a row
// of MAX_PROCS cells. Every request sends a probe down the row, one cell per clock.
// A fence that does not complete the barrier, a query from an unknown process and a fence
// on a full table take one pass. A query from a known process needs a second pass to
// compare every active slot with its epoch, and a fence that releases the barrier needs a
// second pass to recount the slots at or past the new group epoch. One request is in work
// at a time; the next is taken while the previous response still waits in the output
// register.
// process_count is written through csr_wr_en / csr_wr_data and must only change while
// the block is idle.

module fence_epoch_barrier_tracker import febt_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   febt_req_if.sink         req_chan,
   febt_rsp_if.source       rsp_chan,
   input  logic             csr_wr_en,
   input  logic [CNT_W-1:0] csr_wr_data
);

   state_type          state_ff, state_in;
   cmd_type            cmd_ff;
   logic [CONN_W-1:0]  conn_ff;
   logic [PROC_W-1:0]  proc_ff;
   logic [CNT_W-1:0]   pcount_ff;
   logic [EPOCH_W-1:0] g_epoch_ff, g_epoch_in;
   logic [CNT_W-1:0]   arr_cnt_ff, arr_cnt_in;
   status_type         res_status_ff, res_status_in;
   logic [EPOCH_W-1:0] res_own_ff, res_own_in;
   logic               res_reached_ff, res_reached_in;
   logic               res_release_ff, res_release_in;
   probe_type          launch_ff, launch_in;
   slot_wr_type        slot_wr;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [EPOCH_W-1:0]  rsp_own_ff;
   logic                rsp_reached_ff;
   logic                rsp_release_ff;
   logic [EPOCH_W-1:0]  rsp_group_ff;

   probe_type          chain [MAX_PROCS+1];
   probe_type          ret;
   logic [CNT_W-1:0]   pc_fix;
   logic [NACT_W-1:0]  n_act;
   logic               req_acc;
   logic               rsp_free;
   logic               go_scan2;
   logic               go_done;
   logic [EPOCH_W-1:0] new_own;
   logic               slot_ok;
   logic [CNT_W-1:0]   cnt_inc;

   // active slot count: zero taken as one, capped at the table size
   assign pc_fix = (pcount_ff == '0) ? CNT_W'(1) : pcount_ff;
   always_comb begin
      if (int'(pc_fix) > MAX_PROCS) begin
         n_act = NACT_W'(MAX_PROCS);
      end else begin
         n_act = NACT_W'(pc_fix);
      end
   end

   assign req_acc  = req_chan.valid && req_chan.ready;
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;
   assign ret      = chain[MAX_PROCS];

   // chain of slot cells
   assign chain[0] = launch_ff;
   for (genvar i = 0; i < MAX_PROCS; i++) begin : g_cell
      febt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_idx (IDX_W'(i)),
         .n_act    (n_act),
         .slot_wr  (slot_wr),
         .up_probe (chain[i]),
         .dn_probe (chain[i+1])
      );
   end

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         pcount_ff <= CNT_W'(1);
      end else if (csr_wr_en) begin
         pcount_ff <= csr_wr_data;
      end
   end

   // fence arithmetic on the returned find probe
   assign cnt_inc = (arr_cnt_ff == CNT_MAX) ? arr_cnt_ff : arr_cnt_ff + 1'b1;
   always_comb begin
      slot_ok = 1'b1;
      new_own = '0;
      if (ret.found) begin
         new_own = epoch_sat_inc(ret.found_epoch);
      end else if (!ret.free_found) begin
         slot_ok = 1'b0;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_acc) state_in = S_FIND;
         end
         S_FIND: begin
            if (go_scan2) begin
               state_in = S_SCAN2;
            end else if (go_done) begin
               state_in = S_DONE;
            end
         end
         S_SCAN2: begin
            if (go_done) state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control outputs: probe launch, slot write and result values
   always_comb begin
      launch_in       = launch_ff;
      launch_in.valid = 1'b0;
      slot_wr         = '0;
      slot_wr.conn    = conn_ff;
      slot_wr.proc    = proc_ff;
      g_epoch_in      = g_epoch_ff;
      arr_cnt_in      = arr_cnt_ff;
      res_status_in   = res_status_ff;
      res_own_in      = res_own_ff;
      res_reached_in  = res_reached_ff;
      res_release_in  = res_release_ff;
      go_scan2        = 1'b0;
      go_done         = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               launch_in        = '0;
               launch_in.valid  = 1'b1;
               launch_in.mode   = PM_FIND;
               launch_in.conn   = req_chan.conn_id;
               launch_in.proc   = req_chan.proc_id;
               launch_in.all_ok = 1'b1;
               res_status_in    = ST_OK;
               res_own_in       = '0;
               res_reached_in   = 1'b0;
               res_release_in   = 1'b0;
            end
         end
         S_FIND: begin
            if (ret.valid) begin
               if (cmd_ff == CMD_FENCE) begin
                  if (!slot_ok) begin
                     // unknown process and no free slot
                     res_status_in = ST_FULL;
                     go_done       = 1'b1;
                  end else begin
                     slot_wr.en    = 1'b1;
                     slot_wr.idx   = ret.found ? ret.found_idx : ret.free_idx;
                     slot_wr.epoch = new_own;
                     res_own_in    = new_own;
                     if (new_own != g_epoch_ff) begin
                        go_done = 1'b1;
                     end else if (int'(cnt_inc) >= int'(n_act)) begin
                        // barrier complete: advance and recount
                        res_release_in    = 1'b1;
                        g_epoch_in        = epoch_sat_inc(g_epoch_ff);
                        launch_in         = '0;
                        launch_in.valid   = 1'b1;
                        launch_in.mode    = PM_COUNT;
                        launch_in.operand = epoch_sat_inc(g_epoch_ff);
                        launch_in.all_ok  = 1'b1;
                        go_scan2          = 1'b1;
                     end else begin
                        arr_cnt_in = cnt_inc;
                        go_done    = 1'b1;
                     end
                  end
               end else begin
                  if (ret.found) begin
                     res_own_in        = ret.found_epoch;
                     launch_in         = '0;
                     launch_in.valid   = 1'b1;
                     launch_in.mode    = PM_CHECK;
                     launch_in.operand = ret.found_epoch;
                     launch_in.all_ok  = 1'b1;
                     go_scan2          = 1'b1;
                  end else begin
                     res_status_in = ST_UNKNOWN;
                     go_done       = 1'b1;
                  end
               end
            end
         end
         S_SCAN2: begin
            if (ret.valid) begin
               if (ret.mode == PM_COUNT) begin
                  arr_cnt_in = ret.count;
               end else begin
                  res_reached_in = ret.all_ok;
               end
               go_done = 1'b1;
            end
         end
         default: begin
            go_done = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         g_epoch_ff      <= '0;
         arr_cnt_ff      <= '0;
         launch_ff.valid <= 1'b0;
      end else begin
         state_ff   <= state_in;
         g_epoch_ff <= g_epoch_in;
         arr_cnt_ff <= arr_cnt_in;
         launch_ff  <= launch_in;
      end
   end

   // request and result holding registers
   always_ff @(posedge clock) begin
      if (req_acc) begin
         cmd_ff  <= cmd_type'(req_chan.cmd);
         conn_ff <= req_chan.conn_id;
         proc_ff <= req_chan.proc_id;
      end
      res_status_ff  <= res_status_in;
      res_own_ff     <= res_own_in;
      res_reached_ff <= res_reached_in;
      res_release_ff <= res_release_in;
   end

   // response output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_DONE && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_DONE && rsp_free) begin
         rsp_status_ff  <= res_status_ff;
         rsp_own_ff     <= res_own_ff;
         rsp_reached_ff <= res_reached_ff;
         rsp_release_ff <= res_release_ff;
         rsp_group_ff   <= g_epoch_ff;
      end
   end

   assign req_chan.ready       = (state_ff == S_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.own_epoch   = rsp_own_ff;
   assign rsp_chan.reached     = rsp_reached_ff;
   assign rsp_chan.release_res = rsp_release_ff;
   assign rsp_chan.group_epoch = rsp_group_ff;

endmodule

[hdl/febt_checker.sv]
// febt_checker: port-level assertions for the epoch barrier tracker, bound to the top
// depends on febt_pkg and on the fence_epoch_barrier_tracker port list

module febt_checker import febt_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [EPOCH_W-1:0]  rsp_own_epoch,
   input logic                rsp_reached,
   input logic                rsp_release_res,
   input logic [EPOCH_W-1:0]  rsp_group_epoch
);

   logic [1:0] outstanding_ff;

   // requests taken but not yet answered
   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_ff + 2'(req_valid && req_ready)
                                          - 2'(rsp_valid && rsp_ready);
      end
   end

   // no response right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // one request at a time: busy after a request is taken
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous request still in work");

   // every response answers a taken request, at most one in work and one waiting
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (outstanding_ff != 2'd0) && (outstanding_ff != 2'd3))
      else $error("response without a matching request");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_own_epoch) && $stable(rsp_reached)
         && $stable(rsp_release_res) && $stable(rsp_group_epoch))
      else $error("stalled response changed");

   // an error response carries no epoch, reach or release
   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |->
         (rsp_own_epoch == '0) && !rsp_reached && !rsp_release_res)
      else $error("error response with nonzero result fields");

endmodule

bind fence_epoch_barrier_tracker febt_checker u_febt_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_status      (rsp_chan.status),
   .rsp_own_epoch   (rsp_chan.own_epoch),
   .rsp_reached     (rsp_chan.reached),
   .rsp_release_res (rsp_chan.release_res),
   .rsp_group_epoch (rsp_chan.group_epoch)
);
